/* hdl/isaac_pkg.sv */
// Shared constants, types and request bundles for the ISAAC64 generator.
package isaac_pkg;

    localparam int LOG2_TABLE_SIZE = 8;
    localparam int ADDR_W          = LOG2_TABLE_SIZE;
    localparam int TSIZE           = 1 << LOG2_TABLE_SIZE;
    localparam int WORD_W          = 64;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_addr ADDR_MAX   = t_addr'(TSIZE - 1);
    localparam t_addr ADDR_HALF  = t_addr'(TSIZE / 2);
    localparam t_addr LAST_BLOCK = t_addr'(TSIZE - 8);
    localparam t_addr BLOCK_STEP = t_addr'(8);

    localparam t_word GOLDEN = 64'h9e3779b97f4a7c13;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic       golden;
        logic       add_rot;
        logic       row_a;
        logic       row_b;
        logic       wr_rot;
        logic [2:0] row;
        t_word      data;
    } t_scr_cmd;

endpackage

/* hdl/isaac64_random_generator.sv */
// Top level of the ISAAC64 generator: sequencer, two table memories, mixer.
//
// Channel  Dir  Signals          Content
// s_axis   in   tdata[23:0]      seed_index, seed_byte, use_seed
//               tuser[1:0]       operation
// m_axis   out  tdata[63:0]      random_word
//
// Regenerating a block runs GSTART and GADDB, then GRH, GRM, GRY, GWY, GRZ and
// GB for each table entry on the single read port of the mix memory; it follows
// the fetch that empties the block. Initialization runs the preliminary mixer
// rounds, then for each group of eight entries an add step (with the seed), a
// mix round and a write-back, twice over the table if seeded, then one block.
// After reset a clearing pass writes zeros into both tables. A waiting result
// beat holds the fetch step but not loads or other inputs.
module isaac64_random_generator
    import isaac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] seed_index, [15:8] seed_byte, [16] use_seed
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] random_word
);

    t_ram_req w_mm_req;
    t_ram_req w_rt_req;
    t_word    w_mm_rdata;
    t_word    w_rt_rdata;
    t_scr_cmd w_scr;
    t_word    w_v0;

    isaac_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_seed_index (i_s_axis_tdata[7:0]),
        .i_seed_byte  (i_s_axis_tdata[15:8]),
        .i_use_seed   (i_s_axis_tdata[16]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_word       (o_m_axis_tdata),
        .o_mm_req     (w_mm_req),
        .i_mm_rdata   (w_mm_rdata),
        .o_rt_req     (w_rt_req),
        .i_rt_rdata   (w_rt_rdata),
        .o_scr        (w_scr),
        .i_v0         (w_v0)
    );

    isaac_ram u_mix_mem (
        .i_clk   (i_clk),
        .i_req   (w_mm_req),
        .o_rdata (w_mm_rdata)
    );

    isaac_ram u_result_mem (
        .i_clk   (i_clk),
        .i_req   (w_rt_req),
        .o_rdata (w_rt_rdata)
    );

    isaac_scramble u_scramble (
        .i_clk (i_clk),
        .i_cmd (w_scr),
        .o_v0  (w_v0)
    );

endmodule

/* hdl/isaac_ram.sv */
// Table memory with one write port and one registered read port.
module isaac_ram
    import isaac_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_word    o_rdata
);

    t_word r_mem [TSIZE];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/isaac_scramble.sv */
// Eight-word mixing register file used by the seeding passes.
module isaac_scramble
    import isaac_pkg::*;
(
    input  logic     i_clk,
    input  t_scr_cmd i_cmd,
    output t_word    o_v0
);

    t_word r_v [8];
    t_word n_v [8];

    // Each row works on fixed places; the file rotates by one word after it.
    function automatic t_word row_shift(input t_word v, input logic [2:0] row);
        t_word s;
        case (row)
            3'd0:    s = v >> 9;
            3'd1:    s = v << 9;
            3'd2:    s = v >> 23;
            3'd3:    s = v << 15;
            3'd4:    s = v >> 14;
            3'd5:    s = v << 20;
            3'd6:    s = v >> 17;
            default: s = v << 14;
        endcase
        return s;
    endfunction

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_v[k] = r_v[k];
        end
        if (i_cmd.golden) begin
            for (int k = 0; k < 8; k++) begin
                n_v[k] = GOLDEN;
            end
        end else if (i_cmd.add_rot) begin
            for (int k = 0; k < 7; k++) begin
                n_v[k] = r_v[k+1];
            end
            n_v[7] = r_v[0] + i_cmd.data;
        end else if (i_cmd.row_a) begin
            n_v[0] = r_v[0] - r_v[4];
            n_v[5] = r_v[5] ^ row_shift(r_v[7], i_cmd.row);
        end else if (i_cmd.row_b) begin
            for (int k = 0; k < 6; k++) begin
                n_v[k] = r_v[k+1];
            end
            n_v[6] = r_v[7] + r_v[0];
            n_v[7] = r_v[0];
        end else if (i_cmd.wr_rot) begin
            for (int k = 0; k < 7; k++) begin
                n_v[k] = r_v[k+1];
            end
            n_v[7] = r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_v[k] <= n_v[k];
        end
    end

    assign o_v0 = r_v[0];

endmodule

/* hdl/isaac_ctrl.sv */
// Sequencer for clearing, seed loads, seeding, block generation and result fetch.
module isaac_ctrl
    import isaac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_seed_index,
    input  logic [7:0] i_seed_byte,
    input  logic       i_use_seed,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_word      o_word,
    output t_ram_req   o_mm_req,
    input  t_word      i_mm_rdata,
    output t_ram_req   o_rt_req,
    input  t_word      i_rt_rdata,
    output t_scr_cmd   o_scr,
    input  t_word      i_v0
);

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_FDATA  = 14'b00000000000100,
        S_ISCR   = 14'b00000000001000,
        S_IADD   = 14'b00000000010000,
        S_IWR    = 14'b00000000100000,
        S_GSTART = 14'b00000001000000,
        S_GADDB  = 14'b00000010000000,
        S_GRH    = 14'b00000100000000,
        S_GRM    = 14'b00001000000000,
        S_GRY    = 14'b00010000000000,
        S_GWY    = 14'b00100000000000,
        S_GRZ    = 14'b01000000000000,
        S_GB     = 14'b10000000000000
    } t_state;

    t_state            r_state;
    t_addr             r_rp;
    t_addr             r_gi;
    t_addr             r_base;
    logic [3:0]        r_k;
    logic [2:0]        r_row;
    logic              r_ph;
    logic [1:0]        r_nscr;
    logic              r_prelim;
    logic              r_pass;
    logic              r_use;
    t_word             r_a;
    t_word             r_b;
    t_word             r_cnt;
    t_word             r_x;
    t_word             r_y;
    logic              r_ovalid;
    t_word             r_oword;
    logic              w_accept;
    logic [ADDR_W+7:0] w_seed_wide;
    t_addr             w_seed_addr;
    t_addr             w_blk_addr;

    function automatic t_word a_mix(input t_word a, input logic [1:0] sel);
        t_word f;
        case (sel)
            2'd0:    f = ~(a ^ (a << 21));
            2'd1:    f = a ^ (a >> 5);
            2'd2:    f = a ^ (a << 12);
            default: f = a ^ (a >> 33);
        endcase
        return f;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_seed_wide = {{ADDR_W{1'b0}}, i_seed_index};
    assign w_seed_addr = w_seed_wide[ADDR_W-1:0];
    assign w_blk_addr  = r_base + t_addr'(r_k[2:0]);
    assign o_out_valid = r_ovalid;
    assign o_word      = r_oword;

    always_comb begin
        o_mm_req = '0;
        o_rt_req = '0;
        o_scr    = '0;
        o_scr.row = r_row;
        case (r_state)
            S_CLEAR: begin
                o_mm_req.we    = 1'b1;
                o_mm_req.waddr = r_gi;
                o_rt_req.we    = 1'b1;
                o_rt_req.waddr = r_gi;
            end
            S_IDLE: begin
                if (w_accept && i_op == OP_LOAD) begin
                    o_rt_req.we    = 1'b1;
                    o_rt_req.waddr = w_seed_addr;
                    o_rt_req.wdata = {{(WORD_W-8){1'b0}}, i_seed_byte};
                end
                if (w_accept && i_op == OP_FETCH) begin
                    o_rt_req.re    = 1'b1;
                    o_rt_req.raddr = r_rp;
                end
                if (w_accept && i_op == OP_INIT) begin
                    o_scr.golden = 1'b1;
                end
            end
            S_ISCR: begin
                o_scr.row_a = !r_ph;
                o_scr.row_b = r_ph;
            end
            S_IADD: begin
                if (!r_k[3]) begin
                    o_mm_req.re    = r_pass;
                    o_mm_req.raddr = w_blk_addr;
                    o_rt_req.re    = !r_pass;
                    o_rt_req.raddr = w_blk_addr;
                end
                if (r_k != 4'd0) begin
                    o_scr.add_rot = 1'b1;
                    o_scr.data    = r_pass ? i_mm_rdata : i_rt_rdata;
                end
            end
            S_IWR: begin
                o_mm_req.we    = 1'b1;
                o_mm_req.waddr = w_blk_addr;
                o_mm_req.wdata = i_v0;
                o_scr.wr_rot   = 1'b1;
            end
            S_GADDB: begin
                o_mm_req.re    = 1'b1;
                o_mm_req.raddr = r_gi;
            end
            S_GRH: begin
                o_mm_req.re    = 1'b1;
                o_mm_req.raddr = r_gi + ADDR_HALF;
            end
            S_GRM: begin
                o_mm_req.re    = 1'b1;
                o_mm_req.raddr = r_x[3 +: ADDR_W];
            end
            S_GWY: begin
                o_mm_req.we    = 1'b1;
                o_mm_req.waddr = r_gi;
                o_mm_req.wdata = r_y;
            end
            S_GRZ: begin
                o_mm_req.re    = 1'b1;
                o_mm_req.raddr = r_y[ADDR_W+3 +: ADDR_W];
            end
            S_GB: begin
                o_rt_req.we    = 1'b1;
                o_rt_req.waddr = r_gi;
                o_rt_req.wdata = i_mm_rdata + r_x;
                o_mm_req.re    = 1'b1;
                o_mm_req.raddr = r_gi + t_addr'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_rp     <= '0;
            r_gi     <= '0;
            r_base   <= '0;
            r_k      <= '0;
            r_row    <= '0;
            r_ph     <= 1'b0;
            r_nscr   <= '0;
            r_prelim <= 1'b0;
            r_pass   <= 1'b0;
            r_use    <= 1'b0;
            r_a      <= '0;
            r_b      <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_out_ready && r_state != S_FDATA) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_gi <= r_gi + t_addr'(1);
                    if (r_gi == ADDR_MAX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && i_op == OP_INIT) begin
                        r_a      <= '0;
                        r_b      <= '0;
                        r_cnt    <= '0;
                        r_use    <= i_use_seed;
                        r_row    <= '0;
                        r_ph     <= 1'b0;
                        r_nscr   <= '0;
                        r_prelim <= 1'b1;
                        r_pass   <= 1'b0;
                        r_base   <= '0;
                        r_k      <= '0;
                        r_state  <= S_ISCR;
                    end else if (w_accept && i_op == OP_FETCH) begin
                        r_state <= S_FDATA;
                    end
                end
                S_FDATA: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_oword  <= i_rt_rdata;
                        r_rp     <= r_rp + t_addr'(1);
                        r_state  <= (r_rp == ADDR_MAX) ? S_GSTART : S_IDLE;
                    end
                end
                S_ISCR: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_row <= r_row + 3'd1;
                        if (r_row == 3'd7) begin
                            if (r_prelim) begin
                                r_nscr <= r_nscr + 2'd1;
                                if (r_nscr == 2'd3) begin
                                    r_prelim <= 1'b0;
                                    r_state  <= r_use ? S_IADD : S_ISCR;
                                end
                            end else begin
                                r_state <= S_IWR;
                            end
                        end
                    end
                end
                S_IADD: begin
                    if (r_k == 4'd8) begin
                        r_k     <= '0;
                        r_state <= S_ISCR;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_IWR: begin
                    if (r_k == 4'd7) begin
                        r_k    <= '0;
                        r_base <= r_base + BLOCK_STEP;
                        if (r_base == LAST_BLOCK) begin
                            if (!r_pass && r_use) begin
                                r_pass  <= 1'b1;
                                r_state <= S_IADD;
                            end else begin
                                r_state <= S_GSTART;
                            end
                        end else begin
                            r_state <= r_use ? S_IADD : S_ISCR;
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_GSTART: begin
                    r_cnt   <= r_cnt + 64'd1;
                    r_gi    <= '0;
                    r_state <= S_GADDB;
                end
                S_GADDB: begin
                    r_b     <= r_b + r_cnt;
                    r_state <= S_GRH;
                end
                S_GRH: begin
                    r_x     <= i_mm_rdata;
                    r_state <= S_GRM;
                end
                S_GRM: begin
                    r_a     <= a_mix(r_a, r_gi[1:0]) + i_mm_rdata;
                    r_state <= S_GRY;
                end
                S_GRY: begin
                    r_y     <= i_mm_rdata + r_a + r_b;
                    r_state <= S_GWY;
                end
                S_GWY: begin
                    r_state <= S_GRZ;
                end
                S_GRZ: begin
                    r_state <= S_GB;
                end
                S_GB: begin
                    r_b  <= i_mm_rdata + r_x;
                    r_gi <= r_gi + t_addr'(1);
                    if (r_gi == ADDR_MAX) begin
                        r_rp    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_GRH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FDATA))
        else $error("result beat raised outside the fetch step");

    a_rp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rp != $past(r_rp)) |-> ($past(r_state == S_FDATA) || $past(r_state == S_GB)))
        else $error("read pointer moved outside fetch or block end");

    a_mm_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mm_req.we && o_mm_req.re && o_mm_req.waddr == o_mm_req.raddr))
        else $error("mix memory read and write hit the same entry");
`endif

endmodule
